// ----- hw/rtl/alids_pkg.sv -----
// Package with the shared types and constants of the array list block.
`default_nettype none

package alids_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 7;
  localparam int unsigned CAP_FLOOR   = 4;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_PUT,
    S_SW_HI,
    S_SW_MID,
    S_SW_ZERO
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [ADDR_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] item_out;
    logic [ADDR_W-1:0]        found_at;
    logic [CNT_W-1:0]         count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alids_ram.sv -----
// Single-port-write, registered-read memory that holds the list entries.
`default_nettype none

module alids_ram
  import alids_pkg::*;
(
  input  wire logic              clk_i,
  input  wire ram_wr_t           wr_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [MAX_ENTRIES];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/array_list_insert_delete_search.sv -----
// Top level of the array list with append, insert, delete and move-to-front search.
//
//   Channel   Signals                  Direction  Transfer when
//   command   start, busy, req_i       in         start high and busy low at a rising edge
//   result    done_o, rsp_o            out        the one cycle that done_o is high
//   config    cfg_we_i, cfg_wdata_i    in         cfg_we_i high at a rising edge
//
// Append and every rejected command finish at the accepting edge; the result shows
// in the next cycle. Insert and delete walk the entries that move, one memory read
// and one write per cycle. Search reads one entry per cycle from slot zero and,
// on a match away from slot zero, then makes the three reordering writes.
// Reset clears the length and sets capacity to its full value; there is no clearing pass.
// The receiver cannot stall: each result is presented for exactly one cycle.
`default_nettype none

module array_list_insert_delete_search
  import alids_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  output logic                  done_o,
  output rsp_t                  rsp_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_wdata_i
);

  state_e            state_q, state_d;
  cmd_e              op_q, op_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [CAP_W-1:0]  cap_q;
  logic [ADDR_W-1:0] scan_addr_q, scan_addr_d;
  logic [CNT_W-1:0]  scan_left_q, scan_left_d;
  logic              vld_q, vld_d;
  logic [ADDR_W-1:0] last_addr_q, last_addr_d;
  logic [DATA_W-1:0] item_q, item_d;
  logic [DATA_W-1:0] e0_q, e0_d;
  logic [DATA_W-1:0] prev_q, prev_d;
  logic [ADDR_W-1:0] found_q, found_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  ram_wr_t           wr;
  logic [DATA_W-1:0] rd_data;

  logic              accept;
  logic [CAP_W-1:0]  eff_cap;
  logic              room;
  logic [CNT_W-1:0]  pos_ext;
  logic              hit;

  assign accept  = start && !busy;
  assign pos_ext = {1'b0, req_i.position};
  assign hit     = vld_q && (op_q == CMD_SEARCH) && (rd_data == val_q);

  always_comb begin
    if (cap_q <= CAP_W'(1)) begin
      eff_cap = CAP_W'(CAP_FLOOR);
    end else if (cap_q > CAP_W'(MAX_ENTRIES)) begin
      eff_cap = CAP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_q;
    end
  end

  assign room = CAP_W'(len_q) < eff_cap;

  alids_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (scan_addr_q),
    .rd_data_o (rd_data)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (req_i.cmd == CMD_INSERT) begin
            if (pos_ext <= len_q && room) state_d = S_SCAN;
          end else if (req_i.cmd == CMD_DELETE) begin
            if (pos_ext < len_q) state_d = S_SCAN;
          end else if (req_i.cmd == CMD_SEARCH) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (last_addr_q == '0) ? S_IDLE : S_SW_HI;
        end else if (scan_left_q == '0 && !vld_q) begin
          state_d = (op_q == CMD_INSERT) ? S_INS_PUT : S_IDLE;
        end
      end
      S_INS_PUT: state_d = S_IDLE;
      S_SW_HI:   state_d = S_SW_MID;
      S_SW_MID:  state_d = S_SW_ZERO;
      S_SW_ZERO: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath, memory port and result.
  always_comb begin
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    len_d       = len_q;
    scan_addr_d = scan_addr_q;
    scan_left_d = scan_left_q;
    vld_d       = 1'b0;
    last_addr_d = last_addr_q;
    item_d      = item_q;
    e0_d        = e0_q;
    prev_d      = prev_q;
    found_d     = found_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    wr.we       = 1'b0;
    wr.addr     = scan_addr_q;
    wr.data     = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = req_i.cmd;
          pos_d  = req_i.position;
          val_d  = req_i.value;
          item_d = '0;
          rsp_d  = '{status: ST_OK, item_out: '0, found_at: '0, count: len_q};
          unique case (req_i.cmd)
            CMD_APPEND: begin
              done_d = 1'b1;
              if (room) begin
                wr.we       = 1'b1;
                wr.addr     = len_q[ADDR_W-1:0];
                wr.data     = req_i.value;
                len_d       = len_q + CNT_W'(1);
                rsp_d.count = len_q + CNT_W'(1);
              end else begin
                rsp_d.status = ST_FULL;
              end
            end
            CMD_INSERT: begin
              if (pos_ext > len_q) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end else if (!room) begin
                done_d       = 1'b1;
                rsp_d.status = ST_FULL;
              end else begin
                // Entries move up, so the walk starts at the top.
                scan_addr_d = len_q[ADDR_W-1:0] - ADDR_W'(1);
                scan_left_d = len_q - pos_ext;
              end
            end
            CMD_DELETE: begin
              if (pos_ext >= len_q) begin
                done_d       = 1'b1;
                rsp_d.status = ST_RANGE;
              end else begin
                scan_addr_d = req_i.position;
                scan_left_d = len_q - pos_ext;
              end
            end
            CMD_SEARCH: begin
              scan_addr_d = '0;
              scan_left_d = len_q;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // One read is issued per cycle; vld_q marks the registered read data.
        if (scan_left_q != '0 && !hit) begin
          scan_addr_d = (op_q == CMD_INSERT) ? scan_addr_q - ADDR_W'(1)
                                             : scan_addr_q + ADDR_W'(1);
          scan_left_d = scan_left_q - CNT_W'(1);
          vld_d       = 1'b1;
          last_addr_d = scan_addr_q;
        end
        if (vld_q) begin
          unique case (op_q)
            CMD_INSERT: begin
              wr.we   = 1'b1;
              wr.addr = last_addr_q + ADDR_W'(1);
              wr.data = rd_data;
            end
            CMD_DELETE: begin
              if (last_addr_q == pos_q) begin
                item_d = rd_data;
              end else begin
                wr.we   = 1'b1;
                wr.addr = last_addr_q - ADDR_W'(1);
                wr.data = rd_data;
              end
            end
            CMD_SEARCH: begin
              // The word just below the match is kept for the reordering writes.
              if (!hit) prev_d = rd_data;
              if (last_addr_q == '0) e0_d = rd_data;
              if (hit) begin
                found_d = last_addr_q;
                if (last_addr_q == '0) begin
                  done_d = 1'b1;
                  rsp_d  = '{status: ST_OK, item_out: '0, found_at: '0, count: len_q};
                end
              end
            end
            default: ;
          endcase
        end else if (scan_left_q == '0) begin
          if (op_q == CMD_DELETE) begin
            len_d  = len_q - CNT_W'(1);
            done_d = 1'b1;
            rsp_d  = '{status: ST_OK, item_out: item_q, found_at: '0,
                       count: len_q - CNT_W'(1)};
          end else if (op_q == CMD_SEARCH) begin
            done_d = 1'b1;
            rsp_d  = '{status: ST_MISS, item_out: '0, found_at: '0, count: len_q};
          end
        end
      end

      S_INS_PUT: begin
        wr.we   = 1'b1;
        wr.addr = pos_q;
        wr.data = val_q;
        len_d   = len_q + CNT_W'(1);
        done_d  = 1'b1;
        rsp_d   = '{status: ST_OK, item_out: '0, found_at: '0,
                    count: len_q + CNT_W'(1)};
      end

      // The match moves to slot zero, the old front word to the slot just below
      // the match, and that slot's word to where the match was. The write order
      // also covers a match at slot one.
      S_SW_HI: begin
        wr.we   = 1'b1;
        wr.addr = found_q;
        wr.data = prev_q;
      end
      S_SW_MID: begin
        wr.we   = 1'b1;
        wr.addr = found_q - ADDR_W'(1);
        wr.data = e0_q;
      end
      S_SW_ZERO: begin
        wr.we   = 1'b1;
        wr.addr = '0;
        wr.data = val_q;
        done_d  = 1'b1;
        rsp_d   = '{status: ST_OK, item_out: '0, found_at: found_q, count: len_q};
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cap_q       <= CAP_W'(MAX_ENTRIES);
      scan_left_q <= '0;
      vld_q       <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      scan_left_q <= scan_left_d;
      vld_q       <= vld_d;
      done_q      <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    scan_addr_q <= scan_addr_d;
    last_addr_q <= last_addr_d;
    item_q      <= item_d;
    e0_q        <= e0_d;
    prev_q      <= prev_d;
    found_q     <= found_d;
    rsp_q       <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(MAX_ENTRIES))
    else $error("list length beyond the memory depth");

  a_done_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("multi-cycle command finished without a result");

  a_idle_write_is_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.we && state_q == S_IDLE) |-> (accept && req_i.cmd == CMD_APPEND && room))
    else $error("memory written while idle by something other than an append");

  a_swap_not_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SW_HI) |-> (found_q != '0))
    else $error("reordering started for a match at slot zero");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && busy) |-> !done_q)
    else $error("result strobe raised while a command is still running");

endmodule

`default_nettype wire
